[design/umdu_pkg.sv]
// ----------------------------------------------------------------------------
// Unsigned multiply / divide unit package
// Shared widths and the control bundle that the sequencer hands to the cells.
// ----------------------------------------------------------------------------
package umdu_pkg;

	// Width of one operand word.
	localparam int WORD_BITS = 32;

	// Width of the step counter.
	localparam int CNT_BITS = $clog2(WORD_BITS);

	// Operation selector codes.
	localparam logic FUNC_MUL = 1'b0;
	localparam logic FUNC_DIV = 1'b1;

	// Control from the sequencer to the cell row and output register.
	typedef struct packed {
		logic load;     // take a new word into the cells
		logic step;     // run one shift-add or shift-subtract step
		logic div;      // operation of the word in flight is a divide
		logic capture;  // copy the cell row into the output register
	} ctrl_t;

endpackage

[design/unsigned_multiply_divide_unit_core.sv]
// ----------------------------------------------------------------------------
// Unsigned multiply / divide unit
// Full-width unsigned product or quotient and remainder of two words, built
// on a row of bit cells that run one shift-add or restoring step per cycle.
// ----------------------------------------------------------------------------
// Each word is loaded into the cell row at its accepting edge. The cell row
// then runs one step per operand bit, after which the result moves to the
// output register. A new word is accepted in the cycle after the result has
// moved, so the unit takes no new word before the last one has left the
// cell row. If the output register still holds an unread word, the finished
// word waits in the cell row and the input stays stalled until the output is
// read. The bit steps are set by the carry chain through the cells, which
// forms one add or subtract per cycle.
// A multiply returns the low product word in result_low and the high word in
// result_high. A divide returns the quotient in result_low and the remainder
// in result_high; a zero divisor gives a quotient of all ones and the
// dividend as remainder. The output register lets a finished word wait while
// the next one is loaded and computed.
// ----------------------------------------------------------------------------
module unsigned_multiply_divide_unit_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [2*umdu_pkg::WORD_BITS-1:0] s_tdata,  // operand_a, operand_b
	input  logic                            s_tuser,  // func
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [2*umdu_pkg::WORD_BITS-1:0] m_tdata   // result_low, result_high
);
	import umdu_pkg::*;

	ctrl_t                  ctrl;
	logic [WORD_BITS-1:0]   op_a;
	logic [WORD_BITS-1:0]   op_b;
	logic [WORD_BITS-1:0]   ld_a;
	logic [WORD_BITS-1:0]   ld_m;
	logic [WORD_BITS-1:0]   p;
	logic [WORD_BITS-1:0]   a;
	logic [WORD_BITS-1:0]   pick;
	logic [WORD_BITS-1:0]   pick_up;
	logic [WORD_BITS-1:0]   a_up;
	logic [WORD_BITS-1:0]   a_dn;
	logic [WORD_BITS-1:0]   p_dn;
	logic [WORD_BITS:0]     carry;
	logic                   take;
	logic [2*WORD_BITS-1:0] res_q;

	// Sequencer.
	umdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_func   (s_tuser),
		.out_ready (m_tready),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.ctrl      (ctrl)
	);

	// Operand steering: the shift register holds the multiplier or the
	// dividend, the operand register the multiplicand or the divisor.
	always_comb begin
		op_a = s_tdata[WORD_BITS-1:0];
		op_b = s_tdata[2*WORD_BITS-1:WORD_BITS];
		ld_a = (s_tuser == FUNC_DIV) ? op_a : op_b;
		ld_m = (s_tuser == FUNC_DIV) ? op_b : op_a;
	end

	// Step decision: a multiply adds when the multiplier bit is set, a
	// divide keeps the difference when it does not borrow or the shifted
	// remainder overflowed the word.
	assign carry[0] = ctrl.div;
	assign take = ctrl.div ? (p[WORD_BITS-1] | carry[WORD_BITS]) : a[0];

	// Neighbor wiring at the ends of the row.
	always_comb begin
		p_dn[0]              = a[WORD_BITS-1];
		a_dn[0]              = take;
		pick_up[WORD_BITS-1] = take & carry[WORD_BITS];
		a_up[WORD_BITS-1]    = pick[0];
		for (int i = 1; i < WORD_BITS; i++) begin
			p_dn[i]      = p[i-1];
			a_dn[i]      = a[i-1];
			pick_up[i-1] = pick[i];
			a_up[i-1]    = a[i];
		end
	end

	// Row of bit cells.
	for (genvar g = 0; g < WORD_BITS; g++) begin : g_cell
		umdu_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.take    (take),
			.ld_a    (ld_a[g]),
			.ld_m    (ld_m[g]),
			.c_i     (carry[g]),
			.p_dn    (p_dn[g]),
			.pick_up (pick_up[g]),
			.a_up    (a_up[g]),
			.a_dn    (a_dn[g]),
			.p       (p[g]),
			.a       (a[g]),
			.pick    (pick[g]),
			.c_o     (carry[g+1])
		);
	end

	// Output register: low word from the shift register, high word from
	// the accumulator.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			res_q <= {p, a};
		end
	end

	assign m_tdata = res_q;

	// A word never enters while the previous one is still in the cell row.
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while cell row busy");

	// Loading happens exactly on an input handshake.
	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load == (s_tvalid && s_tready))
		else $error("cell load does not match input handshake");

	// A pending result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.capture |-> (!m_tvalid || m_tready))
		else $error("output register overwritten");

	// Steps never coincide with a load or a capture.
	a_step_load_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.step && (ctrl.load || ctrl.capture)))
		else $error("step overlaps load or capture");

endmodule

[design/umdu_cell.sv]
// ----------------------------------------------------------------------------
// Unsigned multiply / divide bit cell
// One bit slice of the datapath: holds one bit each of the accumulator or
// partial remainder, the multiplier or quotient, and the multiplicand or
// divisor. Adds or subtracts in a ripple chain with its neighbors.
// ----------------------------------------------------------------------------
module umdu_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  umdu_pkg::ctrl_t ctrl,
	input  logic           take,     // keep the sum in this step
	input  logic           ld_a,     // load value of the shift bit
	input  logic           ld_m,     // load value of the operand bit
	input  logic           c_i,      // carry from the cell below
	input  logic           p_dn,     // accumulator bit of the cell below
	input  logic           pick_up,  // selected bit of the cell above
	input  logic           a_up,     // shift bit of the cell above
	input  logic           a_dn,     // shift bit of the cell below
	output logic           p,
	output logic           a,
	output logic           pick,
	output logic           c_o
);
	import umdu_pkg::*;

	logic p_q;
	logic a_q;
	logic m_q;
	logic x;
	logic y;
	logic s;

	// A divide works on the remainder shifted up by one and subtracts the
	// divisor; a multiply adds the multiplicand to the accumulator in place.
	always_comb begin
		x    = ctrl.div ? p_dn : p_q;
		y    = ctrl.div ? ~m_q : m_q;
		s    = x ^ y ^ c_i;
		c_o  = (x & y) | (c_i & (x ^ y));
		pick = take ? s : x;
	end

	// Accumulator and shift bit: a multiply shifts the pair down, a divide
	// shifts it up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= 1'b0;
			a_q <= 1'b0;
		end else if (ctrl.load) begin
			p_q <= 1'b0;
			a_q <= ld_a;
		end else if (ctrl.step) begin
			p_q <= ctrl.div ? pick : pick_up;
			a_q <= ctrl.div ? a_dn : a_up;
		end
	end

	// Operand bit, held for the whole operation.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			m_q <= ld_m;
		end
	end

	assign p = p_q;
	assign a = a_q;

endmodule

[design/umdu_ctrl.sv]
// ----------------------------------------------------------------------------
// Unsigned multiply / divide sequencer
// Takes input words, counts the bit steps of the cell row, and hands the
// finished word to the output register.
// ----------------------------------------------------------------------------
module umdu_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_func,
	input  logic            out_ready,
	output logic            in_ready,
	output logic            out_valid,
	output umdu_pkg::ctrl_t ctrl
);
	import umdu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                div_q;
	logic                out_valid_q;
	logic                out_free;

	// The output register is free when empty or being emptied now.
	assign out_free = !out_valid_q || out_ready;

	// Control decode from the current state.
	always_comb begin
		ctrl.load    = (state_q == ST_IDLE) && in_valid;
		ctrl.step    = (state_q == ST_RUN);
		ctrl.div     = div_q;
		ctrl.capture = (state_q == ST_DONE) && out_free;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// State, step counter, operation and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			div_q       <= FUNC_MUL;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						div_q   <= in_func;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(WORD_BITS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[bench/unsigned_multiply_divide_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// Testbench for the unsigned multiply / divide unit
// Sends multiply and divide words through the input stream and compares
// every result word with the full-width product, or with the quotient and
// remainder, that the bench works out for itself. Directed corner cases come
// first. A long output stall then forces the unit to stop its input. Random
// operands follow, with random gaps on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module unsigned_multiply_divide_unit_core_tb;

	import umdu_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 40;
	localparam int RANDOM_WORDS = 1650;

	localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
	localparam logic [WORD_BITS-1:0] TOP_BIT  = ALL_ONES ^ (ALL_ONES >> 1);

	// One result word, laid out as it leaves on m_tdata.
	typedef struct packed {
		logic [WORD_BITS-1:0] high;
		logic [WORD_BITS-1:0] low;
	} result_t;

	// One outstanding operation and the result it must produce.
	typedef struct {
		logic                 func;
		logic [WORD_BITS-1:0] a;
		logic [WORD_BITS-1:0] b;
		result_t              want;
	} pending_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [2*WORD_BITS-1:0] s_tdata = '0;  // operand_a, operand_b
	logic                   s_tuser = FUNC_MUL;  // func
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [2*WORD_BITS-1:0] m_tdata;  // result_low, result_high

	pending_t pending_results[$];
	int       error_count = 0;
	int       cycle_count = 0;
	bit       source_eager = 1'b0;
	bit       sink_eager = 1'b0;
	int       hold_request = 0;

	unsigned_multiply_divide_unit_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock.
	always #CLK_HALF clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d words outstanding",
				pending_results.size());
			$display("unsigned_multiply_divide_unit_core_tb: done, errors");
			$finish;
		end
	end

	// Full product for a multiply; quotient and remainder for a divide.
	// A zero divisor gives all ones and hands the dividend back.
	function automatic result_t mul_div_result(input logic func,
		input logic [WORD_BITS-1:0] a, input logic [WORD_BITS-1:0] b);
		logic [2*WORD_BITS-1:0] product;
		result_t                r;
		if (func == FUNC_MUL) begin
			product = {{WORD_BITS{1'b0}}, a} * {{WORD_BITS{1'b0}}, b};
			r.low  = product[WORD_BITS-1:0];
			r.high = product[2*WORD_BITS-1:WORD_BITS];
		end else if (b == '0) begin
			r.low  = ALL_ONES;
			r.high = a;
		end else begin
			r.low  = a / b;
			r.high = a % b;
		end
		return r;
	endfunction

	// Operand with weight on zero, small values, values near the top and
	// single set bits, so that carries and borrows reach every position.
	function automatic logic [WORD_BITS-1:0] rand_word();
		logic [WORD_BITS-1:0] w;
		case ($urandom_range(0, 7))
			0: w = '0;
			1: w = WORD_BITS'($urandom_range(1, 255));
			2: w = ~WORD_BITS'($urandom_range(0, 255));
			3: w = TOP_BIT >> $urandom_range(0, WORD_BITS - 1);
			default: w = WORD_BITS'($urandom);
		endcase
		return w;
	endfunction

	// Offer one word after a random gap and record its result once taken.
	task automatic issue_word(input logic func, input logic [WORD_BITS-1:0] a,
		input logic [WORD_BITS-1:0] b);
		int       gap;
		pending_t p;
		gap = source_eager ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, a};
		s_tuser  <= func;
		do @(posedge clk); while (!s_tready);
		p.func = func;
		p.a    = a;
		p.b    = b;
		p.want = mul_div_result(func, a, b);
		pending_results.push_back(p);
	endtask

	// Output side: random stalls per word, plus a long hold on request.
	initial begin : result_sink
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = sink_eager ? 0 : $urandom_range(0, 5);
			if (hold_request > 0) begin
				stall += hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// Compare each result word with the oldest outstanding operation.
	always @(posedge clk) begin : result_check
		result_t  got;
		pending_t p;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("unexpected result word: low %h high %h", got.low, got.high);
			end else begin
				p = pending_results.pop_front();
				if (got.low !== p.want.low || got.high !== p.want.high) begin
					error_count++;
					if (error_count <= 10)
						$display("%s %h, %h: low %h (want %h) high %h (want %h)",
							(p.func == FUNC_MUL) ? "mul" : "div", p.a, p.b,
							got.low, p.want.low, got.high, p.want.high);
				end
			end
		end
	end

	// Multiply corners: zero, all ones, a product that lands in the high word.
	task automatic test_multiply_corners();
		issue_word(FUNC_MUL, '0, '0);
		issue_word(FUNC_MUL, ALL_ONES, ALL_ONES);
		issue_word(FUNC_MUL, ALL_ONES, 1);
		issue_word(FUNC_MUL, 1, ALL_ONES);
		issue_word(FUNC_MUL, '0, ALL_ONES);
		issue_word(FUNC_MUL, ALL_ONES, '0);
		issue_word(FUNC_MUL, TOP_BIT, 2);
		issue_word(FUNC_MUL, 32'h0001_0000, 32'h0001_0000);
		issue_word(FUNC_MUL, 32'hAAAA_AAAA, 32'h5555_5555);
	endtask

	// Divide corners: zero divisor, dividend below divisor, and divisors at
	// or above half the range, where the shifted remainder overflows a word.
	task automatic test_divide_corners();
		issue_word(FUNC_DIV, ALL_ONES, '0);
		issue_word(FUNC_DIV, '0, '0);
		issue_word(FUNC_DIV, 32'h1234_5678, '0);
		issue_word(FUNC_DIV, 5, 7);
		issue_word(FUNC_DIV, '0, 5);
		issue_word(FUNC_DIV, 100, 7);
		issue_word(FUNC_DIV, ALL_ONES, ALL_ONES);
		issue_word(FUNC_DIV, ALL_ONES, 1);
		issue_word(FUNC_DIV, ALL_ONES, TOP_BIT);
		issue_word(FUNC_DIV, ~TOP_BIT, TOP_BIT);
		issue_word(FUNC_DIV, TOP_BIT, TOP_BIT);
		issue_word(FUNC_DIV, ALL_ONES, TOP_BIT | 1);
		issue_word(FUNC_DIV, ALL_ONES - 1, ALL_ONES);
	endtask

	// Hold the output off for a long stretch while words keep coming, so the
	// unit fills up and has to stop its input.
	task automatic test_output_backpressure();
		source_eager = 1'b1;
		hold_request = 200;
		repeat (16)
			issue_word(1'($urandom_range(0, 1)), rand_word(), rand_word());
		source_eager = 1'b0;
	endtask

	// Random operands in phases, each phase with its own idling pattern.
	task automatic test_random_mix();
		logic                 func;
		logic [WORD_BITS-1:0] a;
		logic [WORD_BITS-1:0] b;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 50 == 0) begin
				source_eager = ($urandom_range(0, 3) == 0);
				sink_eager   = ($urandom_range(0, 3) == 0);
			end
			func = 1'($urandom_range(0, 1));
			a    = rand_word();
			b    = rand_word();
			// Divisors close to the dividend give quotients of every size.
			if (func == FUNC_DIV && $urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 1) == 0)
					b = a >> $urandom_range(0, WORD_BITS - 1);
				else
					b = a + WORD_BITS'($urandom_range(0, 3));
			end
			issue_word(func, a, b);
		end
		source_eager = 1'b0;
		sink_eager   = 1'b0;
	endtask

	// Sequence of tests and the final verdict.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_multiply_corners();
		test_divide_corners();
		test_output_backpressure();
		test_random_mix();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (error_count == 0)
			$display("unsigned_multiply_divide_unit_core_tb: done, clean");
		else
			$display("unsigned_multiply_divide_unit_core_tb: done, errors");
		$finish;
	end

endmodule

[unsigned_multiply_divide_unit_core.f]
design/umdu_pkg.sv
design/umdu_cell.sv
design/umdu_ctrl.sv
design/unsigned_multiply_divide_unit_core.sv
bench/unsigned_multiply_divide_unit_core_tb.sv
